[src/mbe_pkg.sv]
// Shared types, widths and reset values for the Mandelbrot escape-time block.
// Used by the register file, controller, datapath, interfaces and top level.
// Depends on nothing.
package mbe_pkg;

	// Field widths.
	localparam int IDX_W   = 10;
	localparam int COUNT_W = 24;
	localparam int WORD_W  = 32;
	localparam int STEP_W  = 31;
	localparam int PROD_W  = 2 * WORD_W;

	// Configuration port geometry: five 32-bit registers at byte addresses 4*i.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;

	// Parameter defaults.
	localparam int MAX_SIDE_DEF  = 1024;
	localparam int FRAC_BITS_DEF = 26;

	// Register reset values.
	localparam logic [COUNT_W-1:0]       MAX_ITER_RST   = 24'd1000000;
	localparam logic signed [WORD_W-1:0] REAL_START_RST = -32'sd100663296;
	localparam logic signed [WORD_W-1:0] IMAG_START_RST = -32'sd67108864;
	localparam logic [STEP_W-1:0]        REAL_STEP_RST  = 31'd1677722;
	localparam logic [STEP_W-1:0]        IMAG_STEP_RST  = 31'd536871;

	// Register contents as seen by the datapath.
	typedef struct packed {
		logic [COUNT_W-1:0]       max_iterations;
		logic signed [WORD_W-1:0] real_start;
		logic signed [WORD_W-1:0] imag_start;
		logic [STEP_W-1:0]        real_step;
		logic [STEP_W-1:0]        imag_step;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_pixel;  // capture and clamp the pixel indexes
		logic c_mul;       // index times step products
		logic c_add;       // form c, seed z and the counter
		logic square;      // register the three products of z
		logic step;        // advance z and decrement the counter
		logic out_load;    // move the final counter to the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic finish;      // counter is zero or z has escaped
	} sts_t;

endpackage

[src/mbe_pixel_if.sv]
// Pixel request channel: valid/ready handshake carrying a row and column index.
// Depends on mbe_pkg.
interface mbe_pixel_if;
	logic                      valid;
	logic                      ready;
	logic [mbe_pkg::IDX_W-1:0] row_index;
	logic [mbe_pkg::IDX_W-1:0] column_index;

	modport source(output valid, output row_index, output column_index, input ready);
	modport sink(input valid, input row_index, input column_index, output ready);
endinterface

[src/mbe_result_if.sv]
// Result request channel: valid/ready handshake carrying the remaining count
// and the inside flag. Depends on mbe_pkg.
interface mbe_result_if;
	logic                        valid;
	logic                        ready;
	logic [mbe_pkg::COUNT_W-1:0] remaining_count;
	logic                        inside_set;

	modport source(output valid, output remaining_count, output inside_set, input ready);
	modport sink(input valid, input remaining_count, input inside_set, output ready);
endinterface

[src/mbe_regs.sv]
// APB-style configuration register file for the escape-time block.
// Holds the iteration budget and the coordinate mapping. Depends on mbe_pkg.
module mbe_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mbe_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [mbe_pkg::APB_DATA_W-1:0] pwdata,
	output logic [mbe_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output mbe_pkg::cfg_t                  cfg
);

	// Register indexes (word address).
	localparam logic [2:0] REG_MAX_ITER   = 3'd0;
	localparam logic [2:0] REG_REAL_START = 3'd1;
	localparam logic [2:0] REG_IMAG_START = 3'd2;
	localparam logic [2:0] REG_REAL_STEP  = 3'd3;
	localparam logic [2:0] REG_IMAG_STEP  = 3'd4;

	mbe_pkg::cfg_t cfg_q;
	logic [2:0]    reg_idx;
	logic          wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[mbe_pkg::APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	// Register writes; writes to unused addresses are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_iterations <= mbe_pkg::MAX_ITER_RST;
			cfg_q.real_start     <= mbe_pkg::REAL_START_RST;
			cfg_q.imag_start     <= mbe_pkg::IMAG_START_RST;
			cfg_q.real_step      <= mbe_pkg::REAL_STEP_RST;
			cfg_q.imag_step      <= mbe_pkg::IMAG_STEP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MAX_ITER:   cfg_q.max_iterations <= pwdata[mbe_pkg::COUNT_W-1:0];
				REG_REAL_START: cfg_q.real_start     <= pwdata[mbe_pkg::WORD_W-1:0];
				REG_IMAG_START: cfg_q.imag_start     <= pwdata[mbe_pkg::WORD_W-1:0];
				REG_REAL_STEP:  cfg_q.real_step      <= pwdata[mbe_pkg::STEP_W-1:0];
				REG_IMAG_STEP:  cfg_q.imag_step      <= pwdata[mbe_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		unique case (reg_idx)
			REG_MAX_ITER:   prdata = {{(mbe_pkg::APB_DATA_W-mbe_pkg::COUNT_W){1'b0}},
				cfg_q.max_iterations};
			REG_REAL_START: prdata = cfg_q.real_start;
			REG_IMAG_START: prdata = cfg_q.imag_start;
			REG_REAL_STEP:  prdata = {1'b0, cfg_q.real_step};
			REG_IMAG_STEP:  prdata = {1'b0, cfg_q.imag_step};
			default:        prdata = '0;
		endcase
	end

endmodule

[src/mbe_ctrl.sv]
// Controller state machine for the escape-time block: sequences the mapping of
// the pixel to c, the square/update loop and the output handshake. Depends on mbe_pkg.
module mbe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  mbe_pkg::sts_t sts,
	output mbe_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CMUL = 3'd1;
	localparam logic [2:0] ST_CADD = 3'd2;
	localparam logic [2:0] ST_SQ   = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_HOLD = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;

	// The output register can take a result when it is empty or being drained.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and command decode.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_pixel = 1'b1;
					state_nxt      = ST_CMUL;
				end
			end
			ST_CMUL: begin
				cmd.c_mul = 1'b1;
				state_nxt = ST_CADD;
			end
			ST_CADD: begin
				cmd.c_add = 1'b1;
				state_nxt = ST_SQ;
			end
			ST_SQ: begin
				cmd.square = 1'b1;
				state_nxt  = ST_UPD;
			end
			ST_UPD: begin
				if (!sts.finish) begin
					cmd.step  = 1'b1;
					state_nxt = ST_SQ;
				end else if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end else begin
					state_nxt = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/mbe_dp.sv]
// Datapath of the escape-time block: index clamp, mapping to c, the complex
// square-and-add of z, the norm test and the output register. Depends on mbe_pkg.
module mbe_dp #(
	parameter int MAX_SIDE  = mbe_pkg::MAX_SIDE_DEF,
	parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  mbe_pkg::cfg_t                      cfg,
	input  mbe_pkg::cmd_t                      cmd,
	output mbe_pkg::sts_t                      sts,
	input  logic [mbe_pkg::IDX_W-1:0]          row_index,
	input  logic [mbe_pkg::IDX_W-1:0]          column_index,
	output logic [mbe_pkg::COUNT_W-1:0]        remaining_count,
	output logic                               inside_set
);

	localparam int W     = mbe_pkg::WORD_W;
	localparam int PW    = mbe_pkg::PROD_W;
	localparam int CPW   = mbe_pkg::IDX_W + mbe_pkg::STEP_W;
	localparam int NORM_SHIFT = 2 * FRAC_BITS + 2;
	// When 4.0 lies beyond the 64-bit norm scale, every norm counts as below it.
	localparam bit NORM_OPEN  = (NORM_SHIFT > PW - 1);
	localparam logic [PW-1:0] NORM_LIMIT = NORM_OPEN ? '0 : (PW'(1) << NORM_SHIFT);
	localparam logic [mbe_pkg::IDX_W-1:0] IDX_CLAMP = mbe_pkg::IDX_W'(MAX_SIDE - 1);

	// Saturate a 64-bit signed value to the 32-bit signed range.
	function automatic logic signed [W-1:0] sat_word(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = PW'($signed({1'b0, {(W-1){1'b1}}}));
		lo = PW'($signed({1'b1, {(W-1){1'b0}}}));
		if (v > hi) begin
			sat_word = {1'b0, {(W-1){1'b1}}};
		end else if (v < lo) begin
			sat_word = {1'b1, {(W-1){1'b0}}};
		end else begin
			sat_word = v[W-1:0];
		end
	endfunction

	logic [mbe_pkg::IDX_W-1:0]   row_q;
	logic [mbe_pkg::IDX_W-1:0]   col_q;
	logic [CPW-1:0]              row_prod_s1;
	logic [CPW-1:0]              col_prod_s1;
	logic signed [W-1:0]         cr_q;
	logic signed [W-1:0]         ci_q;
	logic signed [W-1:0]         zr_q;
	logic signed [W-1:0]         zi_q;
	logic [mbe_pkg::COUNT_W-1:0] count_q;
	logic signed [PW-1:0]        rr_s1;
	logic signed [PW-1:0]        ii_s1;
	logic signed [PW-1:0]        ri_s1;
	logic [mbe_pkg::COUNT_W-1:0] out_count_q;
	logic                        out_inside_q;

	logic signed [PW-1:0]        c_re_sum;
	logic signed [PW-1:0]        c_im_sum;
	logic signed [PW-1:0]        z_re_sum;
	logic signed [PW-1:0]        z_im_sum;
	logic [PW-1:0]               norm;
	logic                        below_four;

	// Mapping of the pixel to c: start plus index times step, saturated.
	assign c_re_sum = PW'(cfg.real_start) + $signed(PW'(row_prod_s1));
	assign c_im_sum = PW'(cfg.imag_start) + $signed(PW'(col_prod_s1));

	// Next z: floor-shifted square terms plus c.
	assign z_re_sum = ((rr_s1 - ii_s1) >>> FRAC_BITS) + PW'(cr_q);
	assign z_im_sum = (ri_s1 >>> (FRAC_BITS - 1)) + PW'(ci_q);

	// Escape test on the exact norm of the current z.
	assign norm       = $unsigned(rr_s1) + $unsigned(ii_s1);
	assign below_four = NORM_OPEN || (norm < NORM_LIMIT);
	assign sts.finish = (count_q == '0) || !below_four;

	assign remaining_count = out_count_q;
	assign inside_set      = out_inside_q;

	// Datapath registers; payload only, so no reset is needed.
	always_ff @(posedge clk) begin
		if (cmd.load_pixel) begin
			row_q <= (32'(row_index) >= MAX_SIDE) ? IDX_CLAMP : row_index;
			col_q <= (32'(column_index) >= MAX_SIDE) ? IDX_CLAMP : column_index;
		end
		if (cmd.c_mul) begin
			row_prod_s1 <= CPW'(row_q) * CPW'(cfg.real_step);
			col_prod_s1 <= CPW'(col_q) * CPW'(cfg.imag_step);
		end
		if (cmd.c_add) begin
			cr_q    <= sat_word(c_re_sum);
			ci_q    <= sat_word(c_im_sum);
			zr_q    <= sat_word(c_re_sum);
			zi_q    <= sat_word(c_im_sum);
			count_q <= cfg.max_iterations;
		end
		if (cmd.square) begin
			rr_s1 <= PW'(zr_q) * PW'(zr_q);
			ii_s1 <= PW'(zi_q) * PW'(zi_q);
			ri_s1 <= PW'(zr_q) * PW'(zi_q);
		end
		if (cmd.step) begin
			zr_q    <= sat_word(z_re_sum);
			zi_q    <= sat_word(z_im_sum);
			count_q <= count_q - 1'b1;
		end
		if (cmd.out_load) begin
			out_count_q  <= count_q;
			out_inside_q <= (count_q == '0);
		end
	end

endmodule

[src/mandelbrot_escape_time.sv]
// Mandelbrot escape-time engine. Each pixel request (row, column) is mapped to
// c = (real_start + row*real_step) + i*(imag_start + column*imag_step) in signed
// Q5.26 (FRAC_BITS fraction bits), then z = z*z + c is iterated from z = c
// while the budget max_iterations lasts and |z|^2 < 4. The result gives the
// budget left over and an inside flag that is set when it reached zero. One
// pixel is worked on at a time: each iteration forms the three 32x32 products
// of z in the square state, then does the norm test and the update of z in the
// update state. A finished result waits in an output register, so the next
// pixel is accepted while it is still held.
// Depends on mbe_pkg, mbe_pixel_if, mbe_result_if, mbe_regs, mbe_ctrl, mbe_dp.
module mandelbrot_escape_time #(
	parameter int MAX_SIDE  = mbe_pkg::MAX_SIDE_DEF,
	parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mbe_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [mbe_pkg::APB_DATA_W-1:0] pwdata,
	output logic [mbe_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	mbe_pixel_if.sink                      pixel,
	mbe_result_if.source                   result
);

	mbe_pkg::cfg_t cfg;
	mbe_pkg::cmd_t cmd;
	mbe_pkg::sts_t sts;

	// Configuration registers.
	mbe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer.
	mbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic.
	mbe_dp #(
		.MAX_SIDE  (MAX_SIDE),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk             (clk),
		.cfg             (cfg),
		.cmd             (cmd),
		.sts             (sts),
		.row_index       (pixel.row_index),
		.column_index    (pixel.column_index),
		.remaining_count (result.remaining_count),
		.inside_set      (result.inside_set)
	);

endmodule

[src/mbe_checker.sv]
// Port-level checks for the escape-time block, attached to the top level by the
// bind statement at the end of this file. Depends on mbe_pkg.
module mbe_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [mbe_pkg::COUNT_W-1:0] remaining_count,
	input logic                        inside_set
);

	// The inside flag marks exactly a used-up budget.
	a_inside_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (inside_set == (remaining_count == '0)))
		else $error("inside flag disagrees with remaining count");

	// Only one pixel is in work: no request is taken in the cycle after one.
	a_one_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second pixel accepted while one is in work");

	// A result cannot appear straight after a pixel is taken.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result appeared too soon after a pixel");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(remaining_count) && $stable(inside_set)))
		else $error("stalled result changed");

endmodule

bind mandelbrot_escape_time mbe_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (pixel.valid),
	.in_ready        (pixel.ready),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.remaining_count (result.remaining_count),
	.inside_set      (result.inside_set)
);

[bench/tb_mandelbrot_escape_time.sv]
`timescale 1ns / 100ps
// Self-checking bench for mandelbrot_escape_time: pixel requests in, escape counts out.
// Each accepted pixel is iterated by a bit-exact fixed-point predictor in the bench.
// Depends on mbe_pkg, mbe_pixel_if, mbe_result_if and the block itself.
module tb_mandelbrot_escape_time;

	// Fixed-point format and limits used by the escape predictor.
	localparam int          FRAC          = mbe_pkg::FRAC_BITS_DEF;
	localparam longint      ONE           = 64'sd1 <<< FRAC;
	localparam longint      WORD_MAX      = 64'sd2147483647;
	localparam longint      WORD_MIN      = -64'sd2147483648;
	localparam logic [63:0] ESCAPE_NORM   = 64'd1 << (2 * FRAC + 2);
	localparam int          WATCHDOG_LIMIT = 20000;
	localparam int          SETTLE_CYCLES  = 8;

	// Register indexes on the configuration port; the spare slots start at REG_COUNT.
	typedef enum int unsigned {
		REG_MAX_ITER,
		REG_REAL_START,
		REG_IMAG_START,
		REG_REAL_STEP,
		REG_IMAG_STEP,
		REG_COUNT
	} cfg_reg_e;

	typedef struct packed {
		logic [mbe_pkg::COUNT_W-1:0] remaining_count;
		logic                        inside_set;
	} escape_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [mbe_pkg::APB_ADDR_W-1:0] paddr;
	logic [mbe_pkg::APB_DATA_W-1:0] pwdata;
	logic [mbe_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	mbe_pixel_if  pixel_bus ();
	mbe_result_if result_bus ();

	mandelbrot_escape_time uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pixel   (pixel_bus),
		.result  (result_bus)
	);

	// Bench copy of the configuration registers.
	logic [mbe_pkg::COUNT_W-1:0]       budget_cfg   = mbe_pkg::MAX_ITER_RST;
	logic signed [mbe_pkg::WORD_W-1:0] re_start_cfg = mbe_pkg::REAL_START_RST;
	logic signed [mbe_pkg::WORD_W-1:0] im_start_cfg = mbe_pkg::IMAG_START_RST;
	logic [mbe_pkg::STEP_W-1:0]        re_step_cfg  = mbe_pkg::REAL_STEP_RST;
	logic [mbe_pkg::STEP_W-1:0]        im_step_cfg  = mbe_pkg::IMAG_STEP_RST;

	escape_t pending_escapes[$];
	int      mismatch_count = 0;
	int      idle_cycles    = 0;
	int      send_idle_pct  = 38;
	int      recv_idle_pct  = 80;

	initial begin
		forever #5 clk = ~clk;
	end

	// Saturate a wide value to the signed 32-bit coordinate range.
	function automatic longint clip_word(longint v);
		if (v > WORD_MAX)
			return WORD_MAX;
		if (v < WORD_MIN)
			return WORD_MIN;
		return v;
	endfunction

	// Escape-time iteration for one pixel under the current register copy.
	function automatic escape_t predict_escape(logic [mbe_pkg::IDX_W-1:0] row,
			logic [mbe_pkg::IDX_W-1:0] col);
		longint                      cr, ci, zr, zi, re_part, im_part;
		logic [63:0]                 norm;
		logic [mbe_pkg::COUNT_W-1:0] left;
		bit                          escaped;
		escape_t                     e;
		cr = clip_word(longint'(re_start_cfg) + longint'(row) * longint'(re_step_cfg));
		ci = clip_word(longint'(im_start_cfg) + longint'(col) * longint'(im_step_cfg));
		zr = cr;
		zi = ci;
		left = budget_cfg;
		escaped = 1'b0;
		while (left != 0 && !escaped) begin
			// The norm is exact and unsigned; both squares together can reach 2^63.
			norm = 64'(zr * zr) + 64'(zi * zi);
			if (norm >= ESCAPE_NORM) begin
				escaped = 1'b1;
			end else begin
				// Arithmetic shifts round towards minus infinity.
				re_part = (zr * zr - zi * zi) >>> FRAC;
				im_part = (zr * zi) >>> (FRAC - 1);
				left = left - 1'b1;
				zr = clip_word(re_part + cr);
				zi = clip_word(im_part + ci);
			end
		end
		e.remaining_count = left;
		e.inside_set = (left == 0);
		return e;
	endfunction

	// One register write: setup phase, access phase, then the bus goes idle.
	task automatic apb_write(int unsigned index, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= mbe_pkg::APB_ADDR_W'(4 * index);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (index)
			REG_MAX_ITER:   budget_cfg = value[mbe_pkg::COUNT_W-1:0];
			REG_REAL_START: re_start_cfg = value;
			REG_IMAG_START: im_start_cfg = value;
			REG_REAL_STEP:  re_step_cfg = value[mbe_pkg::STEP_W-1:0];
			REG_IMAG_STEP:  im_step_cfg = value[mbe_pkg::STEP_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(logic [31:0] budget, logic [31:0] re0, logic [31:0] im0,
			logic [31:0] re_step, logic [31:0] im_step);
		apb_write(REG_MAX_ITER, budget);
		apb_write(REG_REAL_START, re0);
		apb_write(REG_IMAG_START, im0);
		apb_write(REG_REAL_STEP, re_step);
		apb_write(REG_IMAG_STEP, im_step);
	endtask

	// Offer one pixel request, with random idle cycles ahead of it, and record
	// the expected escape once the block takes it.
	task automatic send_pixel(logic [mbe_pkg::IDX_W-1:0] row, logic [mbe_pkg::IDX_W-1:0] col);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_bus.valid <= 1'b0;
			@(posedge clk);
		end
		pixel_bus.valid <= 1'b1;
		pixel_bus.row_index <= row;
		pixel_bus.column_index <= col;
		do @(posedge clk); while (!pixel_bus.ready);
		pending_escapes.push_back(predict_escape(row, col));
	endtask

	// Stop offering pixels and wait until every expected result has come back.
	task automatic drain_results();
		pixel_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_escapes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Pixels under the reset configuration that escape at once or after one step.
	task automatic test_reset_values();
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(1023, 0);
		send_pixel(0, 1023);
		drain_results();
	endtask

	// Zero budget, the largest budget, and coordinates that saturate.
	task automatic test_budget_extremes();
		set_config(0, 0, 0, 1000, 1000);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		drain_results();
		set_config(32'h00FF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(1, 0);
		drain_results();
		// c = 1 escapes after exactly one step, so the full budget barely moves.
		set_config(32'h00FF_FFFF, 32'(ONE), 0, 0, 0);
		send_pixel(5, 5);
		drain_results();
	endtask

	// A quarter-unit grid over [-2, 2] x [-2, 2]: interior points, cycles, and
	// points whose norm sits exactly on 4.
	task automatic test_grid_points();
		set_config(100, 32'(-2 * ONE), 32'(-2 * ONE), 32'(ONE / 4), 32'(ONE / 4));
		send_pixel(8, 8);    // origin, never moves
		send_pixel(4, 8);    // c = -1, period two
		send_pixel(8, 12);   // c = i, period two after one step
		send_pixel(9, 8);    // c = 0.25, slow approach to the cusp
		send_pixel(1, 8);    // c = -1.75
		send_pixel(10, 8);   // c = 0.5, escapes after a few steps
		send_pixel(0, 8);    // c = -2, norm exactly 4
		send_pixel(16, 8);   // c = 2, norm exactly 4
		send_pixel(8, 16);   // c = 2i, norm exactly 4
		send_pixel(0, 0);    // c = -2 - 2i, outside from the start
		drain_results();
		apb_write(REG_MAX_ITER, 1);
		send_pixel(8, 8);
		drain_results();
	endtask

	// Writes to the spare register slots must leave the configuration alone.
	task automatic test_spare_registers();
		int k;
		for (k = 0; k < 3; k++)
			apb_write(REG_COUNT + k, $urandom());
		send_pixel(10, 8);
		send_pixel(16, 8);
		drain_results();
	endtask

	// Random pixels over several random configurations. Most settings frame a
	// window around the set so that points iterate; some are fully random.
	task automatic test_random_pixels(int sender_pct, int receiver_pct, int num_items);
		int          n;
		logic [31:0] budget, re0, im0, re_step, im_step;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		for (n = 0; n < num_items; n++) begin
			if (n % 50 == 0) begin
				drain_results();
				budget = ($urandom_range(15) == 0) ? 0 : $urandom_range(96, 1);
				if ($urandom_range(3) == 0) begin
					re0 = $urandom();
					im0 = $urandom();
					re_step = $urandom();
					im_step = $urandom();
				end else begin
					re0 = $urandom_range(234881024) - 167772160;
					im0 = $urandom_range(100663296) - 100663296;
					re_step = $urandom_range(300000);
					im_step = $urandom_range(300000);
				end
				set_config(budget, re0, im0, re_step, im_step);
				if ($urandom_range(3) == 0)
					apb_write(REG_COUNT + $urandom_range(2), $urandom());
			end
			send_pixel(mbe_pkg::IDX_W'($urandom_range(1023)),
				mbe_pkg::IDX_W'($urandom_range(1023)));
		end
		drain_results();
	endtask

	// Result checking and receiver stalls.
	always @(posedge clk) begin : check_results
		escape_t want;
		if (result_bus.valid && result_bus.ready) begin
			if (pending_escapes.size() == 0) begin
				$error("unexpected result: remaining_count %0d, inside_set %0d",
					result_bus.remaining_count, result_bus.inside_set);
				mismatch_count++;
			end else begin
				want = pending_escapes.pop_front();
				if (result_bus.remaining_count !== want.remaining_count) begin
					$error("remaining_count: expected %0d, actual %0d",
						want.remaining_count, result_bus.remaining_count);
					mismatch_count++;
				end
				if (result_bus.inside_set !== want.inside_set) begin
					$error("inside_set: expected %0d, actual %0d",
						want.inside_set, result_bus.inside_set);
					mismatch_count++;
				end
			end
		end
		result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: too long without any request moving on either channel.
	always @(posedge clk) begin
		if ((pixel_bus.valid && pixel_bus.ready) || (result_bus.valid && result_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Main sequence.
	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pixel_bus.valid <= 1'b0;
		pixel_bus.row_index <= '0;
		pixel_bus.column_index <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_budget_extremes();
		test_grid_points();
		test_spare_registers();
		test_random_pixels(38, 80, 200);
		test_random_pixels(80, 38, 200);
		test_random_pixels(0, 0, 200);

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
src/mbe_pkg.sv
src/mbe_pixel_if.sv
src/mbe_result_if.sv
src/mbe_regs.sv
src/mbe_ctrl.sv
src/mbe_dp.sv
src/mandelbrot_escape_time.sv
src/mbe_checker.sv
bench/tb_mandelbrot_escape_time.sv
